/* hw/rtl/rts_pkg.sv */
// shared types, codes and helpers for the rtc time sequencer
package rts_pkg;

    // default number of clock registers transferred
    localparam int NUM_REGS_DEFAULT = 7;

    // configuration register indexes and reset values
    localparam logic [0:0] REG_DEVICE_ADDRESS = 1'b0;
    localparam logic [6:0] DEV_ADDR_RESET     = 7'd104;

    // command codes on the input word
    localparam logic [1:0] CMD_READ = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_DONE = 2'd2;

    // bus master operation codes
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_RACK  = 3'd3;
    localparam logic [2:0] OP_RNACK = 3'd4;
    localparam logic [2:0] OP_STOP  = 3'd5;

    // expected master status codes, upper five bits compared
    localparam logic [7:0] ST_START_SENT  = 8'h08;
    localparam logic [7:0] ST_RSTART_SENT = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK    = 8'h18;
    localparam logic [7:0] ST_DATA_ACK    = 8'h28;
    localparam logic [7:0] ST_SLAR_ACK    = 8'h40;
    localparam logic [7:0] ST_RDATA_ACK   = 8'h50;
    localparam logic [7:0] ST_RDATA_NACK  = 8'h58;

    // register pointer sent after address+write
    localparam logic [7:0] REG_POINTER = 8'h00;

    // set request bytes, register 0 in the lowest byte
    typedef logic [6:0][7:0] t_set_bytes;

    // one result word
    typedef struct packed {
        logic       error;
        logic       done_res;
        logic [6:0] year;
        logic [6:0] month;
        logic [6:0] day_of_month;
        logic [3:0] weekday;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
        logic [7:0] tx_byte;
        logic [2:0] bus_op;
    } t_result;

    // tens in bits 6:4, units in bits 3:0, plain arithmetic for bad digits
    function automatic logic [6:0] bcd_decode(input logic [7:0] b);
        return ({4'd0, b[6:4]} * 7'd10) + {3'd0, b[3:0]};
    endfunction

endpackage

/* hw/rtl/i2c_rtc_time_sequencer_unit.sv */
// top level: config register, sequencer and output buffer
// Drives a byte-level I2C master through the read or set of a clock chip's time
// registers, one bus event word in, one result word out. A word on the slave side
// carries a command in tuser (begin read, begin set, or operation completed) with the
// master's status and received byte; each accepted word yields exactly one result
// word on the master side, naming the next bus operation and, on the step that ends
// a read, the BCD-decoded time fields. A word is taken every clock cycle: the
// sequencer state updates in one pass at the accepting edge and the result lands in
// a two-entry output buffer, so the first result appears in the cycle after its word and
// s_tready drops only while both buffer entries hold untaken results. There is no
// clearing pass after reset. The device address register sits at byte address 0 and
// should be written only while no transaction is in progress.
module i2c_rtc_time_sequencer_unit #(
    parameter int NUM_REGS = rts_pkg::NUM_REGS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    // event words in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [1:0]  i_s_tuser,  // cmd
    // bus_status, rx_byte, set_second, set_minute, set_hour, set_weekday,
    // set_date, set_month, set_year
    input  logic [71:0] i_s_tdata,
    // result words out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [2:0]  o_m_tuser,  // bus_op
    // tx_byte, second, minute, hour, weekday, day_of_month, month, year,
    // done_res, error
    output logic [55:0] o_m_tdata
);

    logic [6:0]       r_dev;
    logic             in_accept;
    rts_pkg::t_result res, out_res;

    // device address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev <= rts_pkg::DEV_ADDR_RESET;
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && i_paddr[2] == rts_pkg::REG_DEVICE_ADDRESS) begin
            r_dev <= i_pwdata[6:0];
        end
    end

    assign o_pready   = 1'b1;
    assign o_prdata   = (i_paddr[2] == rts_pkg::REG_DEVICE_ADDRESS) ? 32'(r_dev) : 32'd0;

    assign in_accept = i_s_tvalid && o_s_tready;

    // sequencer
    rts_ctrl #(
        .NUM_REGS (NUM_REGS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_cmd        (i_s_tuser),
        .i_bus_status (i_s_tdata[7:0]),
        .i_rx_byte    (i_s_tdata[15:8]),
        .i_set_bytes  (i_s_tdata[71:16]),
        .i_dev_addr   (r_dev),
        .o_res        (res)
    );

    // output buffer
    rts_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (res),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_res)
    );

    // result word packing
    assign o_m_tuser = out_res.bus_op;
    assign o_m_tdata = {out_res.error, out_res.done_res, out_res.year, out_res.month,
                        out_res.day_of_month, out_res.weekday, out_res.hour,
                        out_res.minute, out_res.second, out_res.tx_byte};

    // a step never both finishes and aborts
    a_done_xor_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[54] && o_m_tdata[55]))
        else $error("done and error on the same result");

    // an abort or a finish always issues stop
    a_end_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[54] || o_m_tdata[55]) |-> o_m_tuser == rts_pkg::OP_STOP)
        else $error("transaction ended without stop");

    // time fields stay clear unless a read finished
    a_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[54] |-> o_m_tdata[53:8] == 46'd0)
        else $error("time fields set outside a finished read");

    // a full skid entry implies the result register is occupied
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("skid entry held with empty result register");

endmodule

/* hw/rtl/rts_ctrl.sv */
// sequencer state machine, byte stores and result formation
module rts_ctrl #(
    parameter int NUM_REGS = rts_pkg::NUM_REGS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_cmd,
    input  logic [7:0]          i_bus_status,
    input  logic [7:0]          i_rx_byte,
    input  rts_pkg::t_set_bytes i_set_bytes,
    input  logic [6:0]          i_dev_addr,
    output rts_pkg::t_result    o_res
);

    localparam int         IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int         DEC_N = (NUM_REGS < 7) ? NUM_REGS : 7;
    localparam logic [2:0] LAST  = 3'(NUM_REGS - 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_SLAW,
        PH_PTR,
        PH_RSTART,
        PH_SLAR,
        PH_RDATA,
        PH_WDATA
    } t_phase;

    t_phase     r_phase, n_phase;
    logic       r_wmode, n_wmode;
    logic [2:0] r_idx, n_idx;

    logic [7:0] r_raw  [NUM_REGS];
    logic [7:0] r_pend [NUM_REGS];

    logic       raw_we, pend_we, decoded;
    logic [7:0] expect_st;
    logic [2:0] idx_inc;
    logic [7:0] dec_byte [7];
    logic [7:0] pend_set [NUM_REGS];

    assign idx_inc = 3'(r_idx + 3'd1);

    // bytes seen by the decoder: stored ones, the last one straight from the bus
    for (genvar k = 0; k < 7; k++) begin : g_dec
        if (k < DEC_N) begin : g_used
            if (k == NUM_REGS - 1) begin : g_last
                assign dec_byte[k] = i_rx_byte;
            end else begin : g_stored
                assign dec_byte[k] = r_raw[k];
            end
        end else begin : g_unused
            assign dec_byte[k] = 8'h00;
        end
    end

    // set bytes as loaded, an eighth register is written as zero
    for (genvar k = 0; k < NUM_REGS; k++) begin : g_pend
        if (k < 7) begin : g_given
            assign pend_set[k] = i_set_bytes[k];
        end else begin : g_zero
            assign pend_set[k] = 8'h00;
        end
    end

    // expected status for the operation in flight
    always_comb begin
        unique case (r_phase)
            PH_START:  expect_st = rts_pkg::ST_START_SENT;
            PH_SLAW:   expect_st = rts_pkg::ST_SLAW_ACK;
            PH_PTR:    expect_st = rts_pkg::ST_DATA_ACK;
            PH_RSTART: expect_st = rts_pkg::ST_RSTART_SENT;
            PH_SLAR:   expect_st = rts_pkg::ST_SLAR_ACK;
            PH_RDATA:  expect_st = (r_idx >= LAST) ? rts_pkg::ST_RDATA_NACK
                                                   : rts_pkg::ST_RDATA_ACK;
            PH_WDATA:  expect_st = rts_pkg::ST_DATA_ACK;
            PH_IDLE:   expect_st = 8'h00;
        endcase
    end

    // next state and result for one event word
    always_comb begin
        n_phase = r_phase;
        n_wmode = r_wmode;
        n_idx   = r_idx;
        raw_we  = 1'b0;
        pend_we = 1'b0;
        decoded = 1'b0;
        o_res   = '0;

        unique case (i_cmd)
            rts_pkg::CMD_READ, rts_pkg::CMD_SET: begin
                if (r_phase == PH_IDLE) begin
                    n_wmode      = (i_cmd == rts_pkg::CMD_SET);
                    pend_we      = (i_cmd == rts_pkg::CMD_SET);
                    n_idx        = 3'd0;
                    n_phase      = PH_START;
                    o_res.bus_op = rts_pkg::OP_START;
                end
            end
            rts_pkg::CMD_DONE: begin
                if (r_phase != PH_IDLE) begin
                    if (i_bus_status[7:3] != expect_st[7:3]) begin
                        o_res.bus_op = rts_pkg::OP_STOP;
                        o_res.error  = 1'b1;
                        n_phase      = PH_IDLE;
                    end else begin
                        unique case (r_phase)
                            PH_START: begin
                                o_res.bus_op  = rts_pkg::OP_WRITE;
                                o_res.tx_byte = {i_dev_addr, 1'b0};
                                n_phase       = PH_SLAW;
                            end
                            PH_SLAW: begin
                                o_res.bus_op  = rts_pkg::OP_WRITE;
                                o_res.tx_byte = rts_pkg::REG_POINTER;
                                n_phase       = PH_PTR;
                            end
                            PH_PTR: begin
                                n_idx = 3'd0;
                                if (r_wmode) begin
                                    o_res.bus_op  = rts_pkg::OP_WRITE;
                                    o_res.tx_byte = r_pend[0];
                                    n_phase       = PH_WDATA;
                                end else begin
                                    o_res.bus_op = rts_pkg::OP_START;
                                    n_phase      = PH_RSTART;
                                end
                            end
                            PH_RSTART: begin
                                o_res.bus_op  = rts_pkg::OP_WRITE;
                                o_res.tx_byte = {i_dev_addr, 1'b1};
                                n_phase       = PH_SLAR;
                            end
                            PH_SLAR: begin
                                n_idx        = 3'd0;
                                o_res.bus_op = (LAST == 3'd0) ? rts_pkg::OP_RNACK
                                                              : rts_pkg::OP_RACK;
                                n_phase      = PH_RDATA;
                            end
                            PH_RDATA: begin
                                raw_we = 1'b1;
                                if (r_idx >= LAST) begin
                                    o_res.bus_op   = rts_pkg::OP_STOP;
                                    o_res.done_res = 1'b1;
                                    decoded        = 1'b1;
                                    n_phase        = PH_IDLE;
                                end else begin
                                    n_idx        = idx_inc;
                                    o_res.bus_op = (idx_inc >= LAST) ? rts_pkg::OP_RNACK
                                                                     : rts_pkg::OP_RACK;
                                end
                            end
                            PH_WDATA: begin
                                if (r_idx >= LAST) begin
                                    o_res.bus_op   = rts_pkg::OP_STOP;
                                    o_res.done_res = 1'b1;
                                    n_phase        = PH_IDLE;
                                end else begin
                                    n_idx         = idx_inc;
                                    o_res.bus_op  = rts_pkg::OP_WRITE;
                                    o_res.tx_byte = r_pend[idx_inc[IDX_W-1:0]];
                                end
                            end
                            PH_IDLE: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // decoded time fields only on a finished read
        if (decoded) begin
            o_res.second       = rts_pkg::bcd_decode(dec_byte[0]);
            o_res.minute       = rts_pkg::bcd_decode(dec_byte[1]);
            o_res.hour         = rts_pkg::bcd_decode(dec_byte[2]);
            o_res.weekday      = dec_byte[3][3:0];
            o_res.day_of_month = rts_pkg::bcd_decode(dec_byte[4]);
            o_res.month        = rts_pkg::bcd_decode(dec_byte[5]);
            o_res.year         = rts_pkg::bcd_decode(dec_byte[6]);
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_wmode <= 1'b0;
            r_idx   <= 3'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_wmode <= n_wmode;
            r_idx   <= n_idx;
        end
    end

    // received bytes
    always_ff @(posedge i_clk) begin
        if (i_accept && raw_we) begin
            r_raw[r_idx[IDX_W-1:0]] <= i_rx_byte;
        end
    end

    // bytes waiting to be written
    always_ff @(posedge i_clk) begin
        if (i_accept && pend_we) begin
            r_pend <= pend_set;
        end
    end

endmodule

/* hw/rtl/rts_obuf.sv */
// two-entry output buffer: result register plus skid register
module rts_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rts_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output rts_pkg::t_result o_data
);

    logic             r_out_valid, r_skid_valid;
    rts_pkg::t_result r_out, r_skid;
    logic             accept, out_free;

    assign o_ready  = !r_skid_valid;
    assign accept   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (out_free) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule
